>>> rtl/core/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising clock edge, skipped while rst is high.
`define SPF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("spf assertion failed");

// Checked on every rising clock edge, reset included.
`define SPF_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("spf assertion failed");

`else

`define SPF_ASSERT(lbl, clk, rst, prop)
`define SPF_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> rtl/core/spf_pkg.sv
package spf_pkg;

   localparam int FRAME_W       = 40;
   localparam int CRC_W         = 6;
   localparam int BITS_PER_CELL = 8;
   localparam int NUM_CELLS     = FRAME_W / BITS_PER_CELL;

   localparam logic [CRC_W-1:0] CRC_SEED = 6'h31;
   localparam logic [CRC_W-1:0] CRC_POLY = 6'h19;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [1:0] STATUS_CRC_FAIL = 2'd2;

   localparam logic MODE_BUILD = 1'b0;
   localparam logic MODE_CHECK = 1'b1;

   localparam logic [6:0] ADDR_BURST_A = 7'h78;
   localparam logic [6:0] ADDR_BURST_B = 7'h7A;
   localparam logic [6:0] ADDR_BURST_C = 7'h7B;
   localparam logic [1:0] ADDR_BURST_PAGE = 2'b11;

   // One word in flight through the CRC cell chain.
   typedef struct packed {
      logic               valid;
      logic               mode;
      logic [FRAME_W-1:0] word;   // frame with CRC bits zero, rotated per cell
      logic [CRC_W-1:0]   rcrc;   // received CRC bits (check mode)
      logic [CRC_W-1:0]   crc;    // running CRC register
   } stage_type;

endpackage

>>> rtl/core/spf_req_if.sv
interface spf_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic        tx_pa;
   logic        tx_rw;
   logic [4:0]  tx_dev_id;
   logic [6:0]  tx_address;
   logic [1:0]  tx_gsw;
   logic [17:0] tx_data;
   logic [39:0] rx_frame;

   modport source (output valid, mode, tx_pa, tx_rw, tx_dev_id, tx_address, tx_gsw,
                   tx_data, rx_frame, input ready);
   modport sink (input valid, mode, tx_pa, tx_rw, tx_dev_id, tx_address, tx_gsw,
                 tx_data, rx_frame, output ready);
endinterface

>>> rtl/core/spf_rsp_if.sv
interface spf_rsp_if;
   logic        valid;
   logic        ready;
   logic [39:0] tx_frame;
   logic [1:0]  rx_status;
   logic        rx_pa;
   logic        rx_rw;
   logic [4:0]  rx_dev_id;
   logic [6:0]  rx_address;
   logic [1:0]  rx_gsw;
   logic [17:0] rx_data;
   logic [5:0]  rx_crc;
   logic [4:0]  rx_burst_index;

   modport source (output valid, tx_frame, rx_status, rx_pa, rx_rw, rx_dev_id,
                   rx_address, rx_gsw, rx_data, rx_crc, rx_burst_index, input ready);
   modport sink (input valid, tx_frame, rx_status, rx_pa, rx_rw, rx_dev_id,
                 rx_address, rx_gsw, rx_data, rx_crc, rx_burst_index, output ready);
endinterface

>>> rtl/core/spf_crc_cell.sv
module spf_crc_cell (
   input  logic               clock,
   input  logic               reset,
   input  spf_pkg::stage_type up,
   output logic               up_ready,
   output spf_pkg::stage_type dn,
   input  logic               dn_ready
);

   logic                          valid_ff;
   spf_pkg::stage_type            stage_ff;
   spf_pkg::stage_type            stage_in;
   logic [spf_pkg::CRC_W-1:0]     crc_next;
   logic                          top_bit;

   assign up_ready = !valid_ff || dn_ready;

   // Take the top BITS_PER_CELL bits MSB first, then rotate them to the bottom.
   always_comb begin
      crc_next = up.crc;
      top_bit  = 1'b0;
      for (int i = 0; i < spf_pkg::BITS_PER_CELL; i++) begin
         top_bit  = crc_next[spf_pkg::CRC_W-1];
         crc_next = {crc_next[spf_pkg::CRC_W-2:0], up.word[spf_pkg::FRAME_W-1-i]};
         if (top_bit) begin
            crc_next = crc_next ^ spf_pkg::CRC_POLY;
         end
      end
      stage_in       = up;
      stage_in.crc   = crc_next;
      stage_in.word  = {up.word[spf_pkg::FRAME_W-spf_pkg::BITS_PER_CELL-1:0],
                        up.word[spf_pkg::FRAME_W-1 -: spf_pkg::BITS_PER_CELL]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up.valid) begin
         stage_ff <= stage_in;
      end
   end

   always_comb begin
      dn       = stage_ff;
      dn.valid = valid_ff;
   end

endmodule

>>> rtl/core/spf_decode.sv
module spf_decode (
   input  logic               clock,
   input  logic               reset,
   input  spf_pkg::stage_type up,
   output logic               up_ready,
   spf_rsp_if.source          rsp
);

   logic        valid_ff;
   logic [39:0] tx_frame_ff, tx_frame_in;
   logic [1:0]  status_ff, status_in;
   logic        pa_ff, pa_in;
   logic        rw_ff, rw_in;
   logic [4:0]  dev_id_ff, dev_id_in;
   logic [6:0]  address_ff, address_in;
   logic [1:0]  gsw_ff, gsw_in;
   logic [17:0] data_ff, data_in;
   logic [5:0]  crc_ff, crc_in;
   logic [4:0]  burst_ff, burst_in;
   logic [6:0]  addr;

   assign up_ready = !valid_ff || rsp.ready;
   assign addr     = up.word[32:26];

   always_comb begin
      tx_frame_in = '0;
      status_in   = spf_pkg::STATUS_OK;
      pa_in       = 1'b0;
      rw_in       = 1'b0;
      dev_id_in   = '0;
      address_in  = '0;
      gsw_in      = '0;
      data_in     = '0;
      crc_in      = '0;
      burst_in    = '0;
      if (up.mode == spf_pkg::MODE_BUILD) begin
         tx_frame_in = {up.word[39:6], up.crc};
      end else if (up.word == '0 && up.rcrc == '0) begin
         status_in = spf_pkg::STATUS_EMPTY;
      end else if (up.crc != up.rcrc) begin
         status_in = spf_pkg::STATUS_CRC_FAIL;
      end else begin
         pa_in      = up.word[39];
         rw_in      = up.word[38];
         dev_id_in  = up.word[37:33];
         address_in = addr;
         gsw_in     = up.word[25:24];
         data_in    = up.word[23:6];
         crc_in     = up.rcrc;
         if (addr[6:5] == spf_pkg::ADDR_BURST_PAGE) begin
            if (addr == spf_pkg::ADDR_BURST_A || addr == spf_pkg::ADDR_BURST_B ||
                addr == spf_pkg::ADDR_BURST_C) begin
               burst_in = 5'd1;
            end else begin
               burst_in = addr[4:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up.valid) begin
         tx_frame_ff <= tx_frame_in;
         status_ff   <= status_in;
         pa_ff       <= pa_in;
         rw_ff       <= rw_in;
         dev_id_ff   <= dev_id_in;
         address_ff  <= address_in;
         gsw_ff      <= gsw_in;
         data_ff     <= data_in;
         crc_ff      <= crc_in;
         burst_ff    <= burst_in;
      end
   end

   assign rsp.valid          = valid_ff;
   assign rsp.tx_frame       = tx_frame_ff;
   assign rsp.rx_status      = status_ff;
   assign rsp.rx_pa          = pa_ff;
   assign rsp.rx_rw          = rw_ff;
   assign rsp.rx_dev_id      = dev_id_ff;
   assign rsp.rx_address     = address_ff;
   assign rsp.rx_gsw         = gsw_ff;
   assign rsp.rx_data        = data_ff;
   assign rsp.rx_crc         = crc_ff;
   assign rsp.rx_burst_index = burst_ff;

endmodule

>>> rtl/core/spi_frame_crc6_codec_top.sv
// CRC-6 protected 40-bit SPI frame codec.
// req_if (sink): one word per handshake (valid && ready). mode 0 packs the
//   tx_* fields into a frame and appends the CRC; mode 1 checks rx_frame,
//   reports status (ok / all-zero / CRC mismatch) and unpacks it.
// rsp_if (source): exactly one result word per request word, in order.
// CRC: seed 0x31, poly 0x19, MSB first over the 40 frame bits with the
//   CRC bits zero. A chain of 5 identical cells each folds 8 bits per cycle
//   into the CRC unless stalled, then one decode stage registers the result.
// Pipeline: 6 register stages (the 5 cells, then decode), the first one
//   loaded at the accepting edge.
// Throughput: one word per cycle unless the chain is stalled.
// Stall: each stage holds its word while the next one is full and stalled;
//   empty stages keep filling, so req_if.ready drops only when all 6
//   stages hold words and rsp_if.ready is low.
// Reset: synchronous, active high; clears all stage valid flags, no words
//   are in flight afterwards. There is no configuration.
`include "assert_macros.svh"

module spi_frame_crc6_codec_top (
   input  logic      clock,
   input  logic      reset,
   spf_req_if.sink   req_if,
   spf_rsp_if.source rsp_if
);

   spf_pkg::stage_type link [0:spf_pkg::NUM_CELLS];
   logic               link_ready [0:spf_pkg::NUM_CELLS];
   logic [39:0]        tx_packed;

   // Assembled frame, CRC field zero until the chain fills it in.
   assign tx_packed = {req_if.tx_pa, req_if.tx_rw, req_if.tx_dev_id, req_if.tx_address,
                       req_if.tx_gsw, req_if.tx_data, 6'd0};

   always_comb begin
      link[0].valid = req_if.valid;
      link[0].mode  = req_if.mode;
      link[0].word  = (req_if.mode == spf_pkg::MODE_BUILD) ? tx_packed
                                                          : {req_if.rx_frame[39:6], 6'd0};
      link[0].rcrc  = req_if.rx_frame[5:0];
      link[0].crc   = spf_pkg::CRC_SEED;
   end

   assign req_if.ready = link_ready[0];

   for (genvar g = 0; g < spf_pkg::NUM_CELLS; g++) begin : g_cell
      spf_crc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up       (link[g]),
         .up_ready (link_ready[g]),
         .dn       (link[g+1]),
         .dn_ready (link_ready[g+1])
      );
   end

   // Final stage: status, field unpack, burst index, output register.
   spf_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .up       (link[spf_pkg::NUM_CELLS]),
      .up_ready (link_ready[spf_pkg::NUM_CELLS]),
      .rsp      (rsp_if)
   );

   // Input backpressure only when the whole chain is full and output stalled.
   `SPF_ASSERT(a_ready_only_on_stall, clock, reset,
               !req_if.ready |-> (rsp_if.valid && !rsp_if.ready))
   // Status code 3 is never produced.
   `SPF_ASSERT(a_status_legal, clock, reset, rsp_if.valid |-> (rsp_if.rx_status != 2'd3))
   // A failed check leaves all unpacked fields zero.
   `SPF_ASSERT(a_fail_clears, clock, reset,
               (rsp_if.valid && rsp_if.rx_status != spf_pkg::STATUS_OK) |->
               (rsp_if.rx_address == 7'd0 && rsp_if.rx_crc == 6'd0 &&
                rsp_if.tx_frame == 40'd0))
   // Build results never carry check-mode status.
   `SPF_ASSERT(a_build_ok, clock, reset,
               (rsp_if.valid && rsp_if.tx_frame != 40'd0) |->
               (rsp_if.rx_status == spf_pkg::STATUS_OK && rsp_if.rx_data == 18'd0))

endmodule

>>> tb/tb_spi_frame_crc6_codec_top.sv
module tb_spi_frame_crc6_codec_top;

   // One request word as the driver presents it.
   typedef struct packed {
      logic        mode;
      logic        pa;
      logic        rw;
      logic [4:0]  dev_id;
      logic [6:0]  address;
      logic [1:0]  gsw;
      logic [17:0] data;
      logic [39:0] frame;
   } frame_req_type;

   // One result word, predicted or observed.
   typedef struct packed {
      logic [39:0] tx_frame;
      logic [1:0]  status;
      logic        pa;
      logic        rw;
      logic [4:0]  dev_id;
      logic [6:0]  address;
      logic [1:0]  gsw;
      logic [17:0] data;
      logic [5:0]  crc;
      logic [4:0]  burst;
   } frame_rsp_type;

   // Receiver pacing styles; each holds for a random span of cycles.
   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PATTERN, RX_CHOKE} rx_pace_type;

   localparam int RANDOM_WORDS   = 1600;
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake on either side
   localparam int SETTLE_CYCLES  = 20;    // pipeline is 6 deep, leave some margin

   logic clock;
   logic reset;

   spf_req_if req_ch ();
   spf_rsp_if rsp_ch ();

   spi_frame_crc6_codec_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   frame_req_type pending_words[$];      // stimulus not yet presented
   frame_rsp_type predicted_results[$];  // results owed by the block, oldest first

   int          mismatch_count;
   int          idle_cycles;
   int          words_sent;
   int          directed_count;
   logic        req_taken;      // the word on req_ch went at the last rising edge
   logic        drain_hold;     // sender waits until every owed result is back
   int          burst_left;
   int          gap_left;
   rx_pace_type rx_pace;
   int          rx_span;
   logic [15:0] rx_pattern;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // CRC-6, MSB first over all 40 bits; caller zeroes the CRC slot.
   function automatic logic [5:0] crc6_of(logic [39:0] f);
      logic [5:0] c;
      logic       top;
      int         i;
      c = spf_pkg::CRC_SEED;
      for (i = 39; i >= 0; i--) begin
         top = c[5];
         c   = {c[4:0], f[i]};
         if (top) c = c ^ spf_pkg::CRC_POLY;
      end
      return c;
   endfunction

   function automatic logic [39:0] sealed_frame(logic pa, logic rw, logic [4:0] dev_id,
                                                logic [6:0] address, logic [1:0] gsw,
                                                logic [17:0] data);
      logic [39:0] body;
      body = {pa, rw, dev_id, address, gsw, data, 6'b0};
      return body | {34'b0, crc6_of(body)};
   endfunction

   function automatic frame_rsp_type predict_result(frame_req_type w);
      frame_rsp_type r;
      r = '0;
      if (w.mode == spf_pkg::MODE_BUILD) begin
         r.tx_frame = sealed_frame(w.pa, w.rw, w.dev_id, w.address, w.gsw, w.data);
      end else if (w.frame == '0) begin
         r.status = spf_pkg::STATUS_EMPTY;
      end else if (crc6_of({w.frame[39:6], 6'b0}) != w.frame[5:0]) begin
         r.status = spf_pkg::STATUS_CRC_FAIL;
      end else begin
         r.status  = spf_pkg::STATUS_OK;
         r.pa      = w.frame[39];
         r.rw      = w.frame[38];
         r.dev_id  = w.frame[37:33];
         r.address = w.frame[32:26];
         r.gsw     = w.frame[25:24];
         r.data    = w.frame[23:6];
         r.crc     = w.frame[5:0];
         // burst page is 0x60..0x7F; three addresses there map to index 1
         if (r.address[6:5] == spf_pkg::ADDR_BURST_PAGE) begin
            if (r.address == spf_pkg::ADDR_BURST_A || r.address == spf_pkg::ADDR_BURST_B ||
                r.address == spf_pkg::ADDR_BURST_C) begin
               r.burst = 5'd1;
            end else begin
               r.burst = r.address[4:0];
            end
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers; the field unused by the mode always carries junk
   // ---------------------------------------------------------------------

   function automatic frame_req_type random_word(logic mode);
      frame_req_type w;
      w.mode    = mode;
      w.pa      = 1'($urandom);
      w.rw      = 1'($urandom);
      w.dev_id  = 5'($urandom);
      w.address = 7'($urandom);
      w.gsw     = 2'($urandom);
      w.data    = 18'($urandom);
      w.frame   = {8'($urandom), 32'($urandom)};
      return w;
   endfunction

   function automatic frame_req_type build_word(logic pa, logic rw, logic [4:0] dev_id,
                                                logic [6:0] address, logic [1:0] gsw,
                                                logic [17:0] data);
      frame_req_type w;
      w         = random_word(spf_pkg::MODE_BUILD);
      w.pa      = pa;
      w.rw      = rw;
      w.dev_id  = dev_id;
      w.address = address;
      w.gsw     = gsw;
      w.data    = data;
      return w;
   endfunction

   function automatic frame_req_type check_word(logic [39:0] frame);
      frame_req_type w;
      w       = random_word(spf_pkg::MODE_CHECK);
      w.frame = frame;
      return w;
   endfunction

   // well-formed frame with random content at a given address
   function automatic logic [39:0] good_frame_at(logic [6:0] address);
      return sealed_frame(1'($urandom), 1'($urandom), 5'($urandom), address,
                          2'($urandom), 18'($urandom));
   endfunction

   function automatic logic [6:0] pick_address();
      if ($urandom_range(0, 1) == 0) return 7'h60 | 7'($urandom_range(0, 31));
      return 7'($urandom);
   endfunction

   task automatic report_mismatch(string what, logic [39:0] got, logic [39:0] want);
      $display("MISMATCH %s: got 0x%0h, want 0x%0h", what, got, want);
      mismatch_count++;
   endtask

   task automatic compare_result(frame_rsp_type got, frame_rsp_type want);
      if (got.tx_frame !== want.tx_frame)
         report_mismatch("tx_frame", got.tx_frame, want.tx_frame);
      if (got.status !== want.status)
         report_mismatch("rx_status", 40'(got.status), 40'(want.status));
      if (got.pa !== want.pa)
         report_mismatch("rx_pa", 40'(got.pa), 40'(want.pa));
      if (got.rw !== want.rw)
         report_mismatch("rx_rw", 40'(got.rw), 40'(want.rw));
      if (got.dev_id !== want.dev_id)
         report_mismatch("rx_dev_id", 40'(got.dev_id), 40'(want.dev_id));
      if (got.address !== want.address)
         report_mismatch("rx_address", 40'(got.address), 40'(want.address));
      if (got.gsw !== want.gsw)
         report_mismatch("rx_gsw", 40'(got.gsw), 40'(want.gsw));
      if (got.data !== want.data)
         report_mismatch("rx_data", 40'(got.data), 40'(want.data));
      if (got.crc !== want.crc)
         report_mismatch("rx_crc", 40'(got.crc), 40'(want.crc));
      if (got.burst !== want.burst)
         report_mismatch("rx_burst_index", 40'(got.burst), 40'(want.burst));
   endtask

   // ---------------------------------------------------------------------
   // Clock
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Driver: falling edge. A presented word stays up until taken; new
   // words go out in bursts with random gaps between them.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin : req_driver
      frame_req_type nxt;
      logic          drive_valid;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         drive_valid = req_ch.valid && !req_taken;
         if (!drive_valid) begin
            // pause point: let the pipe run dry before going on
            if (drain_hold && predicted_results.size() == 0) drain_hold = 1'b0;
            if (burst_left == 0) begin
               if (gap_left > 0) begin
                  gap_left--;
               end else begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                          : $urandom_range(1, 12);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
            if (!drain_hold && burst_left > 0 && pending_words.size() > 0) begin
               nxt = pending_words.pop_front();
               req_ch.mode       <= nxt.mode;
               req_ch.tx_pa      <= nxt.pa;
               req_ch.tx_rw      <= nxt.rw;
               req_ch.tx_dev_id  <= nxt.dev_id;
               req_ch.tx_address <= nxt.address;
               req_ch.tx_gsw     <= nxt.gsw;
               req_ch.tx_data    <= nxt.data;
               req_ch.rx_frame   <= nxt.frame;
               drive_valid = 1'b1;
               burst_left--;
               words_sent++;
               // after the directed part, halfway through, and now and then
               if (words_sent == directed_count ||
                   words_sent == directed_count + RANDOM_WORDS / 2 ||
                   $urandom_range(0, 299) == 0) begin
                  drain_hold = 1'b1;
               end
            end
         end
         req_ch.valid <= drive_valid;
      end
   end

   // ---------------------------------------------------------------------
   // Receiver back-pressure: falling edge, style changes every span
   // ---------------------------------------------------------------------
   always @(negedge clock) begin : rsp_pacer
      logic take;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rx_span == 0) begin
            rx_pace    = rx_pace_type'($urandom_range(0, 3));
            rx_span    = $urandom_range(20, 100);
            rx_pattern = 16'($urandom) | 16'h0001;
         end
         rx_span--;
         case (rx_pace)
            RX_OPEN: take = 1'b1;
            RX_COIN: take = 1'($urandom);
            RX_PATTERN: begin
               take       = rx_pattern[0];
               rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
            end
            default: take = ($urandom_range(0, 3) == 0);
         endcase
         rsp_ch.ready <= take;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: rising edge. Accepted requests become predictions, accepted
   // results are checked against the oldest one.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : word_monitor
      frame_req_type seen_req;
      frame_rsp_type seen_rsp;
      if (reset) begin
         req_taken   <= 1'b0;
         idle_cycles <= 0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen_rsp = {rsp_ch.tx_frame, rsp_ch.rx_status, rsp_ch.rx_pa, rsp_ch.rx_rw,
                        rsp_ch.rx_dev_id, rsp_ch.rx_address, rsp_ch.rx_gsw,
                        rsp_ch.rx_data, rsp_ch.rx_crc, rsp_ch.rx_burst_index};
            if (predicted_results.size() == 0) begin
               report_mismatch("result word with none owed", seen_rsp.tx_frame, '0);
            end else begin
               compare_result(seen_rsp, predicted_results.pop_front());
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            seen_req = {req_ch.mode, req_ch.tx_pa, req_ch.tx_rw, req_ch.tx_dev_id,
                        req_ch.tx_address, req_ch.tx_gsw, req_ch.tx_data,
                        req_ch.rx_frame};
            predicted_results.push_back(predict_result(seen_req));
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus, reset and end of run
   // ---------------------------------------------------------------------
   initial begin : run_control
      logic [39:0] f;
      int          n;
      int          k;
      int          sel;
      logic        timed_out;

      // every input known from time zero
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.mode       = spf_pkg::MODE_BUILD;
      req_ch.tx_pa      = 1'b0;
      req_ch.tx_rw      = 1'b0;
      req_ch.tx_dev_id  = '0;
      req_ch.tx_address = '0;
      req_ch.tx_gsw     = '0;
      req_ch.tx_data    = '0;
      req_ch.rx_frame   = '0;
      rsp_ch.ready      = 1'b0;
      mismatch_count    = 0;
      idle_cycles       = 0;
      words_sent        = 0;
      req_taken         = 1'b0;
      drain_hold        = 1'b0;
      burst_left        = 0;
      gap_left          = 0;
      rx_pace           = RX_OPEN;
      rx_span           = 0;
      rx_pattern        = 16'h0001;

      // directed: field extremes when building
      pending_words.push_back(build_word(1'b0, 1'b0, '0, '0, '0, '0));
      pending_words.push_back(build_word(1'b1, 1'b1, '1, '1, '1, '1));
      pending_words.push_back(build_word(1'b1, 1'b0, '0, '0, '0, '0));
      pending_words.push_back(build_word(1'b0, 1'b1, '0, '0, '0, '0));
      pending_words.push_back(build_word(1'b0, 1'b0, '1, '0, '0, '0));
      pending_words.push_back(build_word(1'b0, 1'b0, '0, '1, '0, '0));
      pending_words.push_back(build_word(1'b0, 1'b0, '0, '0, '1, '0));
      pending_words.push_back(build_word(1'b0, 1'b0, '0, '0, '0, '1));
      // empty frame, also with the pa, dev_id and data junk fields set
      pending_words.push_back(check_word('0));
      f = '0;
      pending_words.push_back(check_word(f));
      pending_words[$].pa = 1'b1; pending_words[$].dev_id = '1; pending_words[$].data = '1;
      // clean frames at the field extremes, then raw all-ones and 0x1 frames
      pending_words.push_back(check_word(sealed_frame(1'b0, 1'b0, '0, '0, '0, '0)));
      pending_words.push_back(check_word(sealed_frame(1'b1, 1'b1, '1, '1, '1, '1)));
      pending_words.push_back(check_word('1));
      pending_words.push_back(check_word(40'h1));
      // CRC mismatch: flipped CRC bit, flipped header bit
      f = sealed_frame(1'b1, 1'b0, 5'h0A, 7'h15, 2'h2, 18'h2AAAA);
      pending_words.push_back(check_word(f ^ 40'h1));
      pending_words.push_back(check_word(f ^ (40'h1 << 39)));
      // burst index: the three special addresses, the page edges, just outside
      pending_words.push_back(check_word(good_frame_at(spf_pkg::ADDR_BURST_A)));
      pending_words.push_back(check_word(good_frame_at(spf_pkg::ADDR_BURST_B)));
      pending_words.push_back(check_word(good_frame_at(spf_pkg::ADDR_BURST_C)));
      pending_words.push_back(check_word(good_frame_at(7'h79)));
      pending_words.push_back(check_word(good_frame_at(7'h60)));
      pending_words.push_back(check_word(good_frame_at(7'h7F)));
      pending_words.push_back(check_word(good_frame_at(7'h5F)));
      pending_words.push_back(check_word(good_frame_at(7'h20)));
      directed_count = pending_words.size();

      // random: mostly builds and clean frames, fewer damaged, raw and empty frames
      for (n = 0; n < RANDOM_WORDS; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 40) begin
            pending_words.push_back(random_word(spf_pkg::MODE_BUILD));
         end else if (sel < 75) begin
            pending_words.push_back(check_word(good_frame_at(pick_address())));
         end else if (sel < 88) begin
            f = good_frame_at(pick_address());
            for (k = $urandom_range(1, 3); k > 0; k--) f[$urandom_range(0, 39)] ^= 1'b1;
            pending_words.push_back(check_word(f));
         end else if (sel < 96) begin
            pending_words.push_back(random_word(spf_pkg::MODE_CHECK));
         end else begin
            pending_words.push_back(check_word('0));
         end
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait until everything is sent and returned, or the watchdog trips
      timed_out = 1'b0;
      while (!(pending_words.size() == 0 && !req_ch.valid &&
               predicted_results.size() == 0)) begin
         @(posedge clock);
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            timed_out = 1'b1;
            break;
         end
      end
      if (timed_out) begin
         $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      end else begin
         // stray words after the last owed one are caught by the monitor
         repeat (SETTLE_CYCLES) @(posedge clock);
      end
      if (predicted_results.size() != 0) begin
         report_mismatch("results never returned", 40'(predicted_results.size()), '0);
      end

      if (!timed_out && mismatch_count == 0) begin
         $display("tb_spi_frame_crc6_codec_top passed");
      end else begin
         $display("tb_spi_frame_crc6_codec_top failed");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/spf_pkg.sv
rtl/core/spf_req_if.sv
rtl/core/spf_rsp_if.sv
rtl/core/spf_crc_cell.sv
rtl/core/spf_decode.sv
rtl/core/spi_frame_crc6_codec_top.sv
tb/tb_spi_frame_crc6_codec_top.sv
